[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ADDR_W     = 12;
	localparam int BYTES_W    = 15;
	localparam int NEED_W     = 13;
	localparam int STEP_W     = 13;
	localparam int GNP_W      = 16;
	localparam int GRAN_W     = 4;
	localparam int STATUS_W   = 2;
	localparam int HEAP_DEPTH = 4096;
	localparam int WORD_BYTES = 8;

	localparam logic [GRAN_W-1:0] GRAN_RESET  = 4'd9;
	localparam logic [ADDR_W-1:0] LIMIT_RESET = 12'd4095;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic REG_GRANULE = 1'b0;
	localparam logic REG_LIMIT   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OOM  = 2'd2;

	typedef logic [4:0] ffha_cmd_t;

	localparam ffha_cmd_t C_NOP         = 5'd0;
	localparam ffha_cmd_t C_ACCEPT      = 5'd1;
	localparam ffha_cmd_t C_NULL        = 5'd2;
	localparam ffha_cmd_t C_FIT_INIT    = 5'd3;
	localparam ffha_cmd_t C_RD_CM1      = 5'd4;
	localparam ffha_cmd_t C_FIT_HDR     = 5'd5;
	localparam ffha_cmd_t C_FIT_EVAL    = 5'd6;
	localparam ffha_cmd_t C_SPLIT_A     = 5'd7;
	localparam ffha_cmd_t C_SPLIT_B     = 5'd8;
	localparam ffha_cmd_t C_SPLIT_C     = 5'd9;
	localparam ffha_cmd_t C_UNLINK      = 5'd10;
	localparam ffha_cmd_t C_GROW_CALC   = 5'd11;
	localparam ffha_cmd_t C_GROW_HDR    = 5'd12;
	localparam ffha_cmd_t C_GROW_END    = 5'd13;
	localparam ffha_cmd_t C_REL_INIT    = 5'd14;
	localparam ffha_cmd_t C_REL_STEP    = 5'd15;
	localparam ffha_cmd_t C_REL_NEXT    = 5'd16;
	localparam ffha_cmd_t C_LINK_A      = 5'd17;
	localparam ffha_cmd_t C_LINK_B      = 5'd18;
	localparam ffha_cmd_t C_RD_NM1      = 5'd19;
	localparam ffha_cmd_t C_MERGE_NA    = 5'd20;
	localparam ffha_cmd_t C_MERGE_NB    = 5'd21;
	localparam ffha_cmd_t C_RD_PM1      = 5'd22;
	localparam ffha_cmd_t C_MERGE_PA    = 5'd23;
	localparam ffha_cmd_t C_MERGE_PB    = 5'd24;
	localparam ffha_cmd_t C_GROW_COMMIT = 5'd25;
	localparam ffha_cmd_t C_REL_OK      = 5'd26;
	localparam ffha_cmd_t C_OOM         = 5'd27;
	localparam ffha_cmd_t C_EMIT        = 5'd28;

	typedef struct packed {
		logic op_release;
		logic bytes_zero;
		logic addr_zero;
		logic cur_zero;
		logic nxt_zero;
		logic prev_zero;
		logic steps_full;
		logic rel_stop;
		logic fit;
		logic split;
		logic rd_eq_nxt;
		logic rd_eq_cur;
		logic grow_bad;
	} ffha_flags_t;

endpackage

[rtl/ffha_req_if.sv]
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel: allocate or release transactions into the allocator.
// ----------------------------------------------------------------------------
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [14:0] request_bytes;
	logic [11:0] address;

	modport source (output valid, operation, request_bytes, address, input ready);
	modport sink (input valid, operation, request_bytes, address, output ready);
endinterface

[rtl/ffha_rsp_if.sv]
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [11:0] slot_address;
	logic [1:0]  status;

	modport source (output valid, slot_address, status, input ready);
	modport sink (input valid, slot_address, status, output ready);
endinterface

[rtl/ffha_cfg_if.sv]
// ----------------------------------------------------------------------------
// ffha_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ffha_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [11:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/ffha_datapath.sv]
// ----------------------------------------------------------------------------
// ffha_datapath
// Heap store, list pointers and arithmetic, driven by controller commands.
// ----------------------------------------------------------------------------
module ffha_datapath import ffha_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffha_cmd_t            cmd,
	input  logic                 operation,
	input  logic [BYTES_W-1:0]   request_bytes,
	input  logic [ADDR_W-1:0]    address,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	output ffha_flags_t          flags,
	output logic [ADDR_W-1:0]    slot_address,
	output logic [STATUS_W-1:0]  status
);

	logic [ADDR_W-1:0]   mem_q [HEAP_DEPTH];
	logic [ADDR_W-1:0]   mem_rd_q;
	logic [ADDR_W-1:0]   w0_q;
	logic                sel0_q;
	logic [ADDR_W-1:0]   rdata;

	logic                we;
	logic [ADDR_W-1:0]   wa;
	logic [ADDR_W-1:0]   wd;
	logic [ADDR_W-1:0]   ra;

	logic [GRAN_W-1:0]   gran_q;
	logic [ADDR_W-1:0]   limit_q;
	logic [ADDR_W-1:0]   head_q;
	logic [ADDR_W-1:0]   top_q;

	logic                op_q;
	logic                bz_q;
	logic                az_q;
	logic [NEED_W-1:0]   need_q;
	logic [ADDR_W-1:0]   cur_q;
	logic [ADDR_W-1:0]   prev_q;
	logic [ADDR_W-1:0]   nxt_q;
	logic [ADDR_W-1:0]   tmp_q;
	logic [ADDR_W-1:0]   lnk_q;
	logic [NEED_W:0]     np_q;
	logic [GNP_W-1:0]    gnp_q;
	logic [STEP_W-1:0]   steps_q;
	logic [ADDR_W-1:0]   res_slot_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   out_slot_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [GNP_W-1:0]    gran_m1;
	logic [GNP_W-1:0]    gnp_sum;
	logic [GNP_W-1:0]    need_sum;
	logic [NEED_W-1:0]   need_d;

	// Word zero lives in a flip-flop so that it reads as zero after reset.
	assign rdata = sel0_q ? w0_q : mem_rd_q;

	always_ff @(posedge clk) begin
		if (we && (wa != '0)) begin
			mem_q[wa] <= wd;
		end
		mem_rd_q <= mem_q[ra];
		sel0_q   <= (ra == '0);
	end

	assign gran_m1  = (GNP_W'(1) << gran_q) - GNP_W'(1);
	assign gnp_sum  = (GNP_W'(top_q) + GNP_W'(need_q) + gran_m1) & ~gran_m1;
	assign need_sum = GNP_W'(request_bytes) + GNP_W'(WORD_BYTES - 1);
	assign need_d   = NEED_W'(need_sum / WORD_BYTES) + NEED_W'(1);

	assign flags.op_release = (op_q == OP_RELEASE);
	assign flags.bytes_zero = bz_q;
	assign flags.addr_zero  = az_q;
	assign flags.cur_zero   = (cur_q == '0);
	assign flags.nxt_zero   = (nxt_q == '0);
	assign flags.prev_zero  = (prev_q == '0);
	assign flags.steps_full = steps_q[STEP_W-1];
	assign flags.rel_stop   = (cur_q < nxt_q);
	assign flags.fit        = (np_q <= (NEED_W + 1)'(nxt_q));
	assign flags.split      = (np_q + 1'b1) < (NEED_W + 1)'(nxt_q);
	assign flags.rd_eq_nxt  = (rdata == nxt_q);
	assign flags.rd_eq_cur  = (rdata == cur_q);
	assign flags.grow_bad   = (gnp_q > GNP_W'(limit_q)) || (gnp_q >= GNP_W'(HEAP_DEPTH));

	always_comb begin
		we = 1'b0;
		wa = cur_q;
		wd = nxt_q;
		ra = cur_q;
		unique case (cmd)
			C_RD_CM1: begin
				ra = cur_q - 1'b1;
			end
			C_FIT_HDR: begin
				ra = cur_q;
			end
			C_FIT_EVAL: begin
				we = flags.fit && flags.split;
				wa = ADDR_W'(np_q - 1'b1);
				wd = nxt_q;
			end
			C_SPLIT_A: begin
				we = 1'b1;
				wa = np_q[ADDR_W-1:0];
				wd = tmp_q;
			end
			C_SPLIT_B: begin
				we = 1'b1;
				wa = cur_q - 1'b1;
				wd = np_q[ADDR_W-1:0];
			end
			C_SPLIT_C: begin
				we = 1'b1;
				wa = cur_q;
				wd = np_q[ADDR_W-1:0];
			end
			C_UNLINK: begin
				we = !flags.prev_zero;
				wa = prev_q;
				wd = lnk_q;
			end
			C_GROW_HDR: begin
				we = 1'b1;
				wa = top_q - 1'b1;
				wd = gnp_q[ADDR_W-1:0];
			end
			C_GROW_END: begin
				we = 1'b1;
				wa = gnp_q[ADDR_W-1:0] - 1'b1;
				wd = '0;
			end
			C_REL_STEP: begin
				ra = nxt_q;
			end
			C_LINK_A: begin
				we = 1'b1;
				wa = cur_q;
				wd = nxt_q;
			end
			C_LINK_B: begin
				we = !flags.prev_zero;
				wa = prev_q;
				wd = cur_q;
			end
			C_RD_NM1: begin
				ra = nxt_q - 1'b1;
			end
			C_MERGE_NA: begin
				we = 1'b1;
				wa = cur_q - 1'b1;
				wd = rdata;
				ra = nxt_q;
			end
			C_MERGE_NB: begin
				we = 1'b1;
				wa = cur_q;
				wd = rdata;
			end
			C_RD_PM1: begin
				ra = prev_q - 1'b1;
			end
			C_MERGE_PA: begin
				we = 1'b1;
				wa = prev_q - 1'b1;
				wd = rdata;
				ra = cur_q;
			end
			C_MERGE_PB: begin
				we = 1'b1;
				wa = prev_q;
				wd = rdata;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gran_q  <= GRAN_RESET;
			limit_q <= LIMIT_RESET;
			head_q  <= '0;
			top_q   <= ADDR_W'(1);
			w0_q    <= '0;
		end else begin
			if (cfg_we && (cfg_index == REG_GRANULE)) begin
				gran_q <= cfg_data[GRAN_W-1:0];
			end
			if (cfg_we && (cfg_index == REG_LIMIT)) begin
				limit_q <= cfg_data;
			end
			if (we && (wa == '0)) begin
				w0_q <= wd;
			end
			if ((cmd == C_UNLINK) && flags.prev_zero) begin
				head_q <= lnk_q;
			end
			if ((cmd == C_LINK_A) && flags.prev_zero) begin
				head_q <= cur_q;
			end
			if (cmd == C_GROW_COMMIT) begin
				top_q <= gnp_q[ADDR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			C_ACCEPT: begin
				op_q   <= operation;
				bz_q   <= (request_bytes == '0);
				az_q   <= (address == '0);
				need_q <= need_d;
				cur_q  <= address;
			end
			C_NULL: begin
				res_slot_q   <= '0;
				res_status_q <= ST_NULL;
			end
			C_FIT_INIT: begin
				prev_q  <= '0;
				cur_q   <= head_q;
				steps_q <= '0;
			end
			C_FIT_HDR: begin
				nxt_q <= rdata;
				np_q  <= (NEED_W + 1)'(cur_q) + (NEED_W + 1)'(need_q);
			end
			C_FIT_EVAL: begin
				if (flags.fit) begin
					tmp_q <= rdata;
					lnk_q <= flags.split ? np_q[ADDR_W-1:0] : rdata;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= rdata;
					steps_q <= steps_q + 1'b1;
				end
			end
			C_UNLINK: begin
				res_slot_q   <= cur_q;
				res_status_q <= ST_DONE;
			end
			C_GROW_CALC: begin
				gnp_q <= gnp_sum;
			end
			C_GROW_END: begin
				cur_q   <= top_q;
				prev_q  <= '0;
				nxt_q   <= head_q;
				steps_q <= '0;
			end
			C_REL_INIT: begin
				prev_q  <= '0;
				nxt_q   <= head_q;
				steps_q <= '0;
			end
			C_REL_STEP: begin
				prev_q  <= nxt_q;
				steps_q <= steps_q + 1'b1;
			end
			C_REL_NEXT: begin
				nxt_q <= rdata;
			end
			C_REL_OK: begin
				res_slot_q   <= '0;
				res_status_q <= ST_DONE;
			end
			C_OOM: begin
				res_slot_q   <= '0;
				res_status_q <= ST_OOM;
			end
			C_EMIT: begin
				out_slot_q   <= res_slot_q;
				out_status_q <= res_status_q;
			end
			default: begin
			end
		endcase
	end

	assign slot_address = out_slot_q;
	assign status       = out_status_q;

endmodule

[rtl/ffha_controller.sv]
// ----------------------------------------------------------------------------
// ffha_controller
// Sequencer for list walks, splitting, growth and coalescing.
// ----------------------------------------------------------------------------
module ffha_controller import ffha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  ffha_flags_t flags,
	output ffha_cmd_t   cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_F_INIT = 5'd2;
	localparam logic [4:0] S_F_CHK  = 5'd3;
	localparam logic [4:0] S_F_HDR  = 5'd4;
	localparam logic [4:0] S_F_EVAL = 5'd5;
	localparam logic [4:0] S_SP2    = 5'd6;
	localparam logic [4:0] S_SP3    = 5'd7;
	localparam logic [4:0] S_SP4    = 5'd8;
	localparam logic [4:0] S_UNLINK = 5'd9;
	localparam logic [4:0] S_G_CALC = 5'd10;
	localparam logic [4:0] S_G_CHK  = 5'd11;
	localparam logic [4:0] S_G_END  = 5'd12;
	localparam logic [4:0] S_R_INIT = 5'd13;
	localparam logic [4:0] S_R_CHK  = 5'd14;
	localparam logic [4:0] S_R_NEXT = 5'd15;
	localparam logic [4:0] S_RL2    = 5'd16;
	localparam logic [4:0] S_RL3    = 5'd17;
	localparam logic [4:0] S_RL4    = 5'd18;
	localparam logic [4:0] S_RL5    = 5'd19;
	localparam logic [4:0] S_RL6    = 5'd20;
	localparam logic [4:0] S_MP1    = 5'd21;
	localparam logic [4:0] S_MP2    = 5'd22;
	localparam logic [4:0] S_MP3    = 5'd23;
	localparam logic [4:0] S_MP4    = 5'd24;
	localparam logic [4:0] S_R_DONE = 5'd25;
	localparam logic [4:0] S_FAIL   = 5'd26;
	localparam logic [4:0] S_DONE   = 5'd27;

	logic [4:0] state_q, state_d;
	logic       grow_q, grow_d;
	logic       retry_q, retry_d;
	logic       out_valid_q;
	logic       emit;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign emit      = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd     = C_NOP;
		state_d = state_q;
		grow_d  = grow_q;
		retry_d = retry_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = C_ACCEPT;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (!flags.op_release) begin
					if (flags.bytes_zero) begin
						cmd     = C_NULL;
						state_d = S_DONE;
					end else begin
						retry_d = 1'b0;
						state_d = S_F_INIT;
					end
				end else if (flags.addr_zero) begin
					cmd     = C_NULL;
					state_d = S_DONE;
				end else begin
					state_d = S_R_INIT;
				end
			end
			S_F_INIT: begin
				cmd     = C_FIT_INIT;
				state_d = S_F_CHK;
			end
			S_F_CHK: begin
				if (flags.cur_zero || flags.steps_full) begin
					state_d = S_G_CALC;
				end else begin
					cmd     = C_RD_CM1;
					state_d = S_F_HDR;
				end
			end
			S_F_HDR: begin
				cmd     = C_FIT_HDR;
				state_d = S_F_EVAL;
			end
			S_F_EVAL: begin
				cmd = C_FIT_EVAL;
				if (!flags.fit) begin
					state_d = S_F_CHK;
				end else if (flags.split) begin
					state_d = S_SP2;
				end else begin
					state_d = S_UNLINK;
				end
			end
			S_SP2: begin
				cmd     = C_SPLIT_A;
				state_d = S_SP3;
			end
			S_SP3: begin
				cmd     = C_SPLIT_B;
				state_d = S_SP4;
			end
			S_SP4: begin
				cmd     = C_SPLIT_C;
				state_d = S_UNLINK;
			end
			S_UNLINK: begin
				cmd     = C_UNLINK;
				state_d = S_DONE;
			end
			S_G_CALC: begin
				cmd     = C_GROW_CALC;
				state_d = S_G_CHK;
			end
			S_G_CHK: begin
				if (flags.grow_bad) begin
					state_d = S_FAIL;
				end else begin
					cmd     = C_GROW_HDR;
					state_d = S_G_END;
				end
			end
			S_G_END: begin
				cmd     = C_GROW_END;
				grow_d  = 1'b1;
				state_d = S_R_CHK;
			end
			S_R_INIT: begin
				cmd     = C_REL_INIT;
				grow_d  = 1'b0;
				state_d = S_R_CHK;
			end
			S_R_CHK: begin
				if (flags.nxt_zero || flags.steps_full || flags.rel_stop) begin
					cmd     = C_LINK_A;
					state_d = S_RL2;
				end else begin
					cmd     = C_REL_STEP;
					state_d = S_R_NEXT;
				end
			end
			S_R_NEXT: begin
				cmd     = C_REL_NEXT;
				state_d = S_R_CHK;
			end
			S_RL2: begin
				cmd     = C_LINK_B;
				state_d = S_RL3;
			end
			S_RL3: begin
				if (flags.nxt_zero) begin
					state_d = S_MP1;
				end else begin
					cmd     = C_RD_CM1;
					state_d = S_RL4;
				end
			end
			S_RL4: begin
				if (flags.rd_eq_nxt) begin
					cmd     = C_RD_NM1;
					state_d = S_RL5;
				end else begin
					state_d = S_MP1;
				end
			end
			S_RL5: begin
				cmd     = C_MERGE_NA;
				state_d = S_RL6;
			end
			S_RL6: begin
				cmd     = C_MERGE_NB;
				state_d = S_MP1;
			end
			S_MP1: begin
				if (flags.prev_zero) begin
					state_d = S_R_DONE;
				end else begin
					cmd     = C_RD_PM1;
					state_d = S_MP2;
				end
			end
			S_MP2: begin
				if (flags.rd_eq_cur) begin
					cmd     = C_RD_CM1;
					state_d = S_MP3;
				end else begin
					state_d = S_R_DONE;
				end
			end
			S_MP3: begin
				cmd     = C_MERGE_PA;
				state_d = S_MP4;
			end
			S_MP4: begin
				cmd     = C_MERGE_PB;
				state_d = S_R_DONE;
			end
			S_R_DONE: begin
				if (grow_q) begin
					cmd = C_GROW_COMMIT;
					if (retry_q) begin
						state_d = S_FAIL;
					end else begin
						retry_d = 1'b1;
						state_d = S_F_INIT;
					end
				end else begin
					cmd     = C_REL_OK;
					state_d = S_DONE;
				end
			end
			S_FAIL: begin
				cmd     = C_OOM;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (emit) begin
					cmd     = C_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			grow_q      <= 1'b0;
			retry_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			grow_q  <= grow_d;
			retry_q <= retry_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit free-list heap manager with splitting, growth and coalescing.
// ----------------------------------------------------------------------------
// The block handles one request transaction at a time and answers each with
// exactly one response transaction. An allocate takes the first free slot
// that fits, splitting it where needed, and the first-fit walk reads the
// header of every free slot that it passes over. When the heap top has to
// grow, a release walk over the free slots ahead of the new one follows, and
// the first-fit walk is then repeated once. A release walks the free slots
// that lie below the released address. Null requests skip the list walks. A
// response that is still waiting to be taken holds back the next one. The
// single-port heap store sets the pace: every list hop is one registered
// read, and every link update is one write.
// The result sits in an output register, so a request can be taken while the
// previous response is still waiting, and the request channel is ready only
// while the sequencer is idle. Configuration writes are accepted at any time
// but are meant to be issued only while no request is outstanding. After
// reset the free list is empty, the heap top is word 1, and the store needs
// no clearing pass: only word zero is defined, every other word is written
// before it is read.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core import ffha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp,
	ffha_cfg_if.sink   cfg
);

	ffha_cmd_t   cmd;
	ffha_flags_t flags;

	// Configuration writes complete in the cycle they are presented.
	assign cfg.ready = 1'b1;

	ffha_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	// The datapath holds the heap store, the free-list head, the heap top and
	// both configuration registers, and updates them on controller commands.
	ffha_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (req.operation),
		.request_bytes (req.request_bytes),
		.address       (req.address),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.flags         (flags),
		.slot_address  (rsp.slot_address),
		.status        (rsp.status)
	);

endmodule

[rtl/ffha_checker.sv]
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker import ffha_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [ADDR_W-1:0]   rsp_slot,
	input logic [STATUS_W-1:0] rsp_status
);

	// A response is held until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_status))
		else $error("response changed while stalled");

	// The block is not ready in the cycle after it takes a request.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken in back-to-back cycles");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_DONE) || (rsp_status == ST_NULL) ||
			(rsp_status == ST_OOM))
		else $error("undefined status code");

	// A nonzero slot address is only ever returned by a successful allocate.
	a_slot_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_slot != '0) |-> rsp_status == ST_DONE)
		else $error("slot returned with failure status");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_slot   (rsp.slot_address),
	.rsp_status (rsp.status)
);
